FILE: rtl/core/lbps_pkg.sv
// lbps_pkg: shared types and constants of the led blink pattern sequencer
// command and mode codes, configuration register indexes, reset values
// no dependencies
`default_nettype none

package lbps_pkg;

  localparam int unsigned ColorW = 24;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [MsW-1:0] MsMax           = {MsW{1'b1}};
  localparam logic [MsW-1:0] BlinkOnReset    = 16'd100;
  localparam logic [MsW-1:0] ContPeriodReset = 16'd500;

  localparam logic [CfgIdxW-1:0] CfgBlinkOn    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgContPeriod = 1'd1;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_VALUE  = 3'd1,
    CMD_SET_SOLID  = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_BLINK_ONCE = 3'd4,
    CMD_BLINK_TWICE = 3'd5,
    CMD_BLINK_CONT = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SOLID = 2'd0,
    MODE_ONCE  = 2'd1,
    MODE_TWICE = 2'd2,
    MODE_CONT  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [MsW-1:0] blink_on_ms;
    logic [MsW-1:0] continuous_period_ms;
  } cfg_t;

  typedef struct packed {
    logic              fire;
    logic [CmdW-1:0]   cmd;
    logic [ColorW-1:0] color;
  } step_t;

  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] color;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/led_blink_pattern_sequencer.sv
// led_blink_pattern_sequencer: top level, command register and block wiring
// depends on lbps_pkg, lbps_cfg_regs, lbps_engine, lbps_out_stage
`default_nettype none

// Takes one command per clock cycle unless in_stall_o is high: tick (one
// millisecond), set_value, set_solid, clear, blink_once, blink_twice and
// blink_continuous. A command is captured in the command register; when it
// moves on, the mode and timer state are updated and any resulting drive
// colour lands in the result register at the same clock edge. A command
// that would drive a colour waits in the command register while the result
// register is held; commands that drive nothing pass through even while the
// result register is held. The duration registers are written through
// the configuration port, which is always ready; write them only while no
// command is in flight.
module led_blink_pattern_sequencer
  import lbps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CmdW-1:0]    command_i,
  input  wire logic [ColorW-1:0]  color_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ColorW-1:0]       drive_color_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [MsW-1:0]     cfg_data_i
);

  logic              cmd_valid_q, cmd_valid_d;
  logic [CmdW-1:0]   cmd_q;
  logic [ColorW-1:0] color_q;
  logic              in_take;
  logic              advance;
  logic              out_free;
  cfg_t              cfg;
  step_t             step;
  result_t           result;

  assign cfg_ready_o = 1'b1;

  lbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a command moves on when its drive transaction has room or it drives nothing
  assign advance    = cmd_valid_q && (out_free || !result.valid);
  assign in_stall_o = cmd_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (in_take) begin
      cmd_valid_d = 1'b1;
    end else if (advance) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= command_i;
      color_q <= color_i;
    end
  end

  assign step.fire  = advance;
  assign step.cmd   = cmd_q;
  assign step.color = color_q;

  lbps_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .result_o (result)
  );

  lbps_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && result.valid),
    .color_i       (result.color),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_color_o (drive_color_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lbps_cfg_regs.sv
// lbps_cfg_regs: the two duration registers behind the configuration port
// depends on lbps_pkg
`default_nettype none

module lbps_cfg_regs
  import lbps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [MsW-1:0]     cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgBlinkOn:    cfg_d.blink_on_ms = cfg_data_i;
        CfgContPeriod: cfg_d.continuous_period_ms = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_on_ms          <= BlinkOnReset;
      cfg_q.continuous_period_ms <= ContPeriodReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/lbps_engine.sv
// lbps_engine: mode, timer and colour state plus the per-command update logic
// depends on lbps_pkg
`default_nettype none

module lbps_engine
  import lbps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  step_t     step_i,
  output result_t   result_o
);

  mode_e             mode_q, mode_d;
  logic              lit_q, lit_d;
  logic [ColorW-1:0] blink_shade_q, blink_shade_d;
  logic [ColorW-1:0] base_shade_q, base_shade_d;
  logic [MsW-1:0]    elapsed_q, elapsed_d;
  logic [MsW-1:0]    elapsed_inc;

  // saturating millisecond count
  assign elapsed_inc = (elapsed_q == MsMax) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    mode_d          = mode_q;
    lit_d           = lit_q;
    blink_shade_d   = blink_shade_q;
    base_shade_d    = base_shade_q;
    elapsed_d       = elapsed_q;
    result_o.valid  = 1'b0;
    result_o.color  = '0;
    unique case (step_i.cmd)
      CMD_TICK: begin
        elapsed_d = elapsed_inc;
        if (mode_q != MODE_SOLID && elapsed_inc >= cfg_i.blink_on_ms) begin
          unique case (mode_q)
            MODE_CONT: begin
              if (elapsed_inc >= cfg_i.continuous_period_ms) begin
                lit_d          = !lit_q;
                elapsed_d      = '0;
                result_o.valid = 1'b1;
                result_o.color = lit_q ? '0 : blink_shade_q;
              end
            end
            MODE_TWICE: begin
              elapsed_d      = '0;
              result_o.valid = 1'b1;
              if (lit_q) begin
                lit_d          = 1'b0;
                result_o.color = '0;
              end else begin
                lit_d          = 1'b1;
                mode_d         = MODE_ONCE;
                result_o.color = blink_shade_q;
              end
            end
            default: begin
              // once mode ends the pattern and restores the base colour
              lit_d          = 1'b0;
              elapsed_d      = '0;
              blink_shade_d  = '0;
              mode_d         = MODE_SOLID;
              result_o.valid = 1'b1;
              result_o.color = base_shade_q;
            end
          endcase
        end
      end
      CMD_SET_VALUE: begin
        base_shade_d   = step_i.color;
        result_o.valid = (mode_q == MODE_SOLID);
        result_o.color = step_i.color;
      end
      CMD_SET_SOLID: begin
        mode_d         = MODE_SOLID;
        base_shade_d   = step_i.color;
        result_o.valid = 1'b1;
        result_o.color = step_i.color;
      end
      CMD_CLEAR: begin
        mode_d         = MODE_SOLID;
        lit_d          = 1'b0;
        blink_shade_d  = '0;
        base_shade_d   = '0;
        elapsed_d      = '0;
        result_o.valid = 1'b1;
      end
      CMD_BLINK_ONCE, CMD_BLINK_TWICE, CMD_BLINK_CONT: begin
        blink_shade_d  = step_i.color;
        elapsed_d      = '0;
        lit_d          = 1'b1;
        result_o.valid = 1'b1;
        result_o.color = step_i.color;
        unique case (step_i.cmd)
          CMD_BLINK_ONCE:  mode_d = MODE_ONCE;
          CMD_BLINK_TWICE: mode_d = MODE_TWICE;
          default:         mode_d = MODE_CONT;
        endcase
      end
      default: begin
        // unused code: no state change, no transaction
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_SOLID;
      lit_q         <= 1'b0;
      blink_shade_q <= '0;
      base_shade_q  <= '0;
      elapsed_q     <= '0;
    end else if (step_i.fire) begin
      mode_q        <= mode_d;
      lit_q         <= lit_d;
      blink_shade_q <= blink_shade_d;
      base_shade_q  <= base_shade_d;
      elapsed_q     <= elapsed_d;
    end
  end

  // once mode is only ever entered with the led lit
  assert property (@(posedge clk_i) disable iff (!rst_ni) (mode_q == MODE_ONCE) |-> lit_q)
    else $error("once mode while unlit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i.fire && step_i.cmd == CMD_CLEAR)
      |=> (mode_q == MODE_SOLID && elapsed_q == '0 && !lit_q && blink_shade_q == '0))
    else $error("clear left state behind");

  // a tick that changes the drive colour in blink mode restarts the timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i.fire && step_i.cmd == CMD_TICK && result_o.valid) |=> (elapsed_q == '0))
    else $error("timer not restarted after toggle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i.fire && (step_i.cmd == CMD_BLINK_ONCE || step_i.cmd == CMD_BLINK_TWICE
                       || step_i.cmd == CMD_BLINK_CONT))
      |=> (lit_q && blink_shade_q == $past(step_i.color) && mode_q != MODE_SOLID))
    else $error("blink start did not load pattern");

endmodule

`default_nettype wire

FILE: rtl/core/lbps_out_stage.sv
// lbps_out_stage: result register that holds a drive colour until taken
// depends on lbps_pkg
`default_nettype none

module lbps_out_stage
  import lbps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic [ColorW-1:0]  color_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ColorW-1:0]       drive_color_o
);

  logic              valid_q, valid_d;
  logic [ColorW-1:0] color_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      color_q <= color_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign drive_color_o = color_q;

endmodule

`default_nettype wire
